FILE: src/tvsg_pkg.sv
// Shared codes, register indexes and types of the three-voice sound generator.
package tvsg_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] PORT_ADDR  = 2'd0;
  localparam logic [1:0] PORT_WRITE = 2'd1;
  localparam logic [1:0] PORT_READ  = 2'd2;

  localparam logic [3:0] REG_NOISE      = 4'd6;
  localparam logic [3:0] REG_MIXER      = 4'd7;
  localparam logic [3:0] REG_AMP_A      = 4'd8;
  localparam logic [3:0] REG_ENV_FINE   = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;
  localparam logic [3:0] REG_PORT_A     = 4'd14;
  localparam logic [3:0] REG_PORT_B     = 4'd15;

  localparam logic [7:0] MIXER_RESET = 8'h80;
  localparam logic [4:0] ENV_TOP     = 5'h1F;

  localparam int NUM_VOICES = 3;
  localparam int NUM_REGS   = 16;

  // Everything the output mixer needs to know about the generator state
  typedef struct packed {
    logic [5:0]      mixer;
    logic [2:0][4:0] amp;
    logic [2:0]      tone_hi;
    logic            noise_hi;
    logic [4:0]      env_vol;
  } mix_state_t;

  function automatic logic [11:0] tone_span(input logic [7:0] fine, input logic [7:0] coarse);
    logic [11:0] p;
    p = {coarse[3:0], fine};
    return (p == 12'd0) ? 12'd1 : p;
  endfunction

endpackage

FILE: src/tvsg_item_if.sv
// Request channel: bus accesses and generator ticks.
interface tvsg_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] port;
  logic [7:0] data;
  logic [7:0] port_a_in;

  modport source (output valid, output cmd, output port, output data, output port_a_in,
                  input ready);
  modport sink (input valid, input cmd, input port, input data, input port_a_in,
                output ready);
endinterface

FILE: src/tvsg_result_if.sv
// Result channel: read data, stereo levels and port B.
interface tvsg_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] rd_byte;
  logic [5:0] left_level;
  logic [5:0] right_level;
  logic       port_b_strobe;
  logic [7:0] port_b_value;

  modport source (output valid, output rd_byte, output left_level, output right_level,
                  output port_b_strobe, output port_b_value, input ready);
  modport sink (input valid, input rd_byte, input left_level, input right_level,
                input port_b_strobe, input port_b_value, output ready);
endinterface

FILE: src/tvsg_mixer.sv
// Voice gating, amplitude selection and stereo sum.
module tvsg_mixer (
  input  tvsg_pkg::mix_state_t st,
  output logic [5:0]           left_level,
  output logic [5:0]           right_level
);
  import tvsg_pkg::*;

  logic [NUM_VOICES-1:0][4:0] lvl;

  always_comb begin
    for (int ch = 0; ch < NUM_VOICES; ch++) begin
      if ((!st.mixer[ch] && !st.tone_hi[ch]) || (!st.mixer[ch+3] && !st.noise_hi)) begin
        lvl[ch] = 5'd0;
      end else if (st.amp[ch][4]) begin
        lvl[ch] = st.env_vol;
      end else if (st.amp[ch][3:0] == 4'd0) begin
        lvl[ch] = 5'd0;
      end else begin
        lvl[ch] = {st.amp[ch][3:0], 1'b1};
      end
    end
  end

  assign left_level  = {1'b0, lvl[0]} + {1'b0, lvl[1]};
  assign right_level = {1'b0, lvl[0]} + {1'b0, lvl[2]};

endmodule

FILE: src/three_voice_sound_generator.sv
// Three-voice sound generator: register file, dividers, noise, envelope, output stage.
// The result of an accepted request is captured in the output register on the edge that accepts it.
// Throughput: one request per cycle; all state advances directly from the accepted
// request, and the next one is taken whenever the output register is empty or drained.
// Reset (synchronous): registers zero except R7 = 0x80, noise shifter 1, envelope step
// 0x1F with hold set; the output register comes up empty.
module three_voice_sound_generator (
  input logic          clk,
  input logic          rst,
  tvsg_item_if.sink    item,
  tvsg_result_if.source result
);
  import tvsg_pkg::*;

  logic [NUM_REGS-1:0][7:0]    regs, regs_next;
  logic [3:0]                  sel, sel_next;
  logic [NUM_VOICES-1:0][11:0] tone_cnt, tone_cnt_next;
  logic [NUM_VOICES-1:0]       tone_hi, tone_hi_next;
  logic [5:0]                  noise_cnt, noise_cnt_next;
  logic [16:0]                 noise_shift, noise_shift_next;
  logic                        noise_hi, noise_hi_next;
  logic [16:0]                 env_count, env_count_next;
  logic [4:0]                  env_step, env_step_next;
  logic [4:0]                  env_attack, env_attack_next;
  logic                        env_hold, env_hold_next;
  logic                        env_alt, env_alt_next;
  logic                        env_holding, env_holding_next;

  logic       accept;
  logic [7:0] rd;
  logic       strobe;
  mix_state_t mix_st;
  logic [5:0] left_mix, right_mix;

  assign item.ready = !result.valid || result.ready;
  assign accept     = item.valid && item.ready;

  always_comb begin
    logic [7:0]  wval;
    logic [11:0] tp;
    logic [12:0] tsum;
    logic [4:0]  nv;
    logic [5:0]  np;
    logic [16:0] ep;
    logic [17:0] esum;
    logic [1:0]  n;
    logic [4:0]  wrapped;

    regs_next        = regs;
    sel_next         = sel;
    tone_cnt_next    = tone_cnt;
    tone_hi_next     = tone_hi;
    noise_cnt_next   = noise_cnt;
    noise_shift_next = noise_shift;
    noise_hi_next    = noise_hi;
    env_count_next   = env_count;
    env_step_next    = env_step;
    env_attack_next  = env_attack;
    env_hold_next    = env_hold;
    env_alt_next     = env_alt;
    env_holding_next = env_holding;
    rd               = 8'hFF;
    strobe           = 1'b0;
    wval             = item.data;
    tp               = 12'd1;
    tsum             = 13'd0;
    nv               = 5'd0;
    np               = 6'd2;
    ep               = 17'd1;
    esum             = 18'd0;
    n                = 2'd0;
    wrapped          = 5'd0;

    if (accept) begin
      case (item.cmd)
        CMD_WRITE: begin
          if (item.port == PORT_ADDR) begin
            sel_next = item.data[3:0];
          end else if (item.port == PORT_WRITE) begin
            // mixer: port A forced to input, bit 7 forced high
            if (sel == REG_MIXER) wval = {2'b10, item.data[5:0]};
            regs_next[sel] = wval;
            strobe = (sel == REG_PORT_B);
            for (int ch = 0; ch < NUM_VOICES; ch++) begin
              if (sel[3:1] == 3'(ch)) begin
                tp = tone_span(regs_next[2*ch], regs_next[2*ch+1]);
                if (tone_cnt[ch] > tp - 12'd1) tone_cnt_next[ch] = tp - 12'd1;
              end
            end
            if (sel == REG_NOISE) begin
              nv = regs_next[REG_NOISE][4:0];
              np = {((nv == 5'd0) ? 5'd1 : nv), 1'b0};
              if (noise_cnt > np - 6'd1) noise_cnt_next = np - 6'd1;
            end
            if (sel == REG_ENV_FINE || sel == REG_ENV_COARSE) begin
              ep = {regs_next[REG_ENV_COARSE], regs_next[REG_ENV_FINE], 1'b0};
              if (ep == 17'd0) ep = 17'd1;
              if (env_count >= ep) env_count_next = ep - 17'd1;
            end
            if (sel == REG_ENV_SHAPE) begin
              env_attack_next  = wval[2] ? ENV_TOP : 5'd0;
              env_holding_next = 1'b0;
              if (!wval[3]) begin
                env_hold_next = 1'b1;
                env_alt_next  = wval[2];
              end else begin
                env_hold_next = wval[0];
                env_alt_next  = wval[1];
              end
              env_count_next = 17'd0;
              env_step_next  = ENV_TOP;
            end
          end
        end
        CMD_READ: begin
          if (item.port == PORT_READ) begin
            if (sel == REG_PORT_A && !regs[REG_MIXER][6]) begin
              regs_next[REG_PORT_A] = item.port_a_in;
              rd = item.port_a_in;
            end else begin
              rd = regs[sel];
            end
          end
        end
        CMD_TICK: begin
          for (int ch = 0; ch < NUM_VOICES; ch++) begin
            tp   = tone_span(regs[2*ch], regs[2*ch+1]);
            tsum = {1'b0, tone_cnt[ch]} + 13'd1;
            if (tsum >= {1'b0, tp}) begin
              tone_cnt_next[ch] = 12'd0;
              tone_hi_next[ch]  = !tone_hi[ch];
            end else begin
              tone_cnt_next[ch] = tsum[11:0];
            end
          end
          nv = regs[REG_NOISE][4:0];
          np = {((nv == 5'd0) ? 5'd1 : nv), 1'b0};
          if (noise_cnt + 6'd1 >= np) begin
            noise_cnt_next   = 6'd0;
            noise_shift_next = {noise_shift[0] ^ noise_shift[3], noise_shift[16:1]};
            noise_hi_next    = noise_shift[1];
          end else begin
            noise_cnt_next = noise_cnt + 6'd1;
          end
          if (!env_holding) begin
            ep = {regs[REG_ENV_COARSE], regs[REG_ENV_FINE], 1'b0};
            esum = {1'b0, env_count} + 18'd2;
            // count stays below the period, so at most one step, or two at period 1
            if (ep == 17'd0) begin
              n = 2'd2;
              env_count_next = 17'd0;
            end else if (esum >= {1'b0, ep}) begin
              n = 2'd1;
              env_count_next = 17'(esum - {1'b0, ep});
            end else begin
              env_count_next = esum[16:0];
            end
            if (n != 2'd0) begin
              if ({3'd0, n} > env_step) begin
                wrapped = env_step - {3'd0, n};
                if (env_hold) begin
                  if (env_alt) env_attack_next = env_attack ^ ENV_TOP;
                  env_holding_next = 1'b1;
                  env_step_next    = 5'd0;
                end else begin
                  if (env_alt && wrapped[4]) env_attack_next = env_attack ^ ENV_TOP;
                  env_step_next = wrapped;
                end
              end else begin
                env_step_next = env_step - {3'd0, n};
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mix_st.mixer    = regs_next[REG_MIXER][5:0];
    mix_st.amp[0]   = regs_next[REG_AMP_A][4:0];
    mix_st.amp[1]   = regs_next[REG_AMP_A+4'd1][4:0];
    mix_st.amp[2]   = regs_next[REG_AMP_A+4'd2][4:0];
    mix_st.tone_hi  = tone_hi_next;
    mix_st.noise_hi = noise_hi_next;
    mix_st.env_vol  = env_step_next ^ env_attack_next;
  end

  tvsg_mixer u_mixer (
    .st          (mix_st),
    .left_level  (left_mix),
    .right_level (right_mix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      regs            <= '0;
      regs[REG_MIXER] <= MIXER_RESET;
      sel             <= '0;
      tone_cnt        <= '0;
      tone_hi         <= '0;
      noise_cnt       <= '0;
      noise_shift     <= 17'd1;
      noise_hi        <= 1'b0;
      env_count       <= '0;
      env_step        <= ENV_TOP;
      env_attack      <= '0;
      env_hold        <= 1'b1;
      env_alt         <= 1'b0;
      env_holding     <= 1'b0;
      result.valid    <= 1'b0;
    end else begin
      regs         <= regs_next;
      sel          <= sel_next;
      tone_cnt     <= tone_cnt_next;
      tone_hi      <= tone_hi_next;
      noise_cnt    <= noise_cnt_next;
      noise_shift  <= noise_shift_next;
      noise_hi     <= noise_hi_next;
      env_count    <= env_count_next;
      env_step     <= env_step_next;
      env_attack   <= env_attack_next;
      env_hold     <= env_hold_next;
      env_alt      <= env_alt_next;
      env_holding  <= env_holding_next;
      result.valid <= accept || (result.valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.rd_byte       <= rd;
      result.left_level    <= left_mix;
      result.right_level   <= right_mix;
      result.port_b_strobe <= strobe;
      result.port_b_value  <= regs_next[REG_PORT_B];
    end
  end

endmodule

FILE: sim/tvsg_output_check.sv
// Output checker: predicts each result from the accepted requests and compares it field by field.
module tvsg_output_check (
  input  logic   clk,
  input  logic   rst,
  tvsg_item_if   req,
  tvsg_result_if res,
  output int     errors,
  output int     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import tvsg_pkg::*;

  localparam int MIXER_PORT_A_OUT = 6;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic [5:0] left_level;
    logic [5:0] right_level;
    logic       port_b_strobe;
    logic [7:0] port_b_value;
  } mix_result_t;

  logic [7:0]  regs [NUM_REGS];
  logic [3:0]  sel;
  int          tone_cnt [NUM_VOICES];
  logic [2:0]  tone_hi;
  int          noise_cnt;
  logic [16:0] lfsr;
  logic        noise_hi;
  int          env_cnt;
  logic [4:0]  env_step;
  logic [4:0]  env_attack;
  logic        env_hold;
  logic        env_alt;
  logic        env_holding;

  mix_result_t due_q[$];
  mix_result_t due;

  function automatic int voice_period(input int v);
    int p;
    p = {regs[2*v+1][3:0], regs[2*v]};
    return (p == 0) ? 1 : p;
  endfunction

  function automatic int noise_span();
    int v;
    v = regs[REG_NOISE][4:0];
    return 2 * ((v == 0) ? 1 : v);
  endfunction

  function automatic int env_period();
    int p;
    p = 2 * {regs[REG_ENV_COARSE], regs[REG_ENV_FINE]};
    return (p == 0) ? 1 : p;
  endfunction

  function automatic void reset_model();
    foreach (regs[i]) regs[i] = 8'h00;
    regs[REG_MIXER] = MIXER_RESET;
    sel = 4'd0;
    foreach (tone_cnt[i]) tone_cnt[i] = 0;
    tone_hi     = 3'b000;
    noise_cnt   = 0;
    lfsr        = 17'd1;
    noise_hi    = 1'b0;
    env_cnt     = 0;
    env_step    = ENV_TOP;
    env_attack  = 5'd0;
    env_hold    = 1'b1;
    env_alt     = 1'b0;
    env_holding = 1'b0;
  endfunction

  function automatic void load_shape(input logic [3:0] s);
    env_attack = s[2] ? ENV_TOP : 5'd0;
    // continue bit clear: one pass, then hold at zero
    if (!s[3]) begin
      env_hold = 1'b1;
      env_alt  = s[2];
    end else begin
      env_hold = s[0];
      env_alt  = s[1];
    end
    env_holding = 1'b0;
    env_cnt     = 0;
    env_step    = ENV_TOP;
  endfunction

  function automatic void reg_write(input logic [3:0] idx, input logic [7:0] v);
    int p;
    int ch;
    if (idx == REG_MIXER) begin
      v[MIXER_PORT_A_OUT] = 1'b0;
      v = v | MIXER_RESET;
    end
    regs[idx] = v;
    if (idx < REG_NOISE) begin
      ch = idx >> 1;
      p = voice_period(ch);
      if (tone_cnt[ch] > p - 1) tone_cnt[ch] = p - 1;
    end else if (idx == REG_NOISE) begin
      p = noise_span();
      if (noise_cnt > p - 1) noise_cnt = p - 1;
    end else if (idx == REG_ENV_FINE || idx == REG_ENV_COARSE) begin
      p = env_period();
      if (env_cnt >= p) env_cnt = p - 1;
    end else if (idx == REG_ENV_SHAPE) begin
      load_shape(v[3:0]);
    end
  endfunction

  function automatic void env_advance(input int n);
    logic [4:0] wrapped;
    if (env_holding) return;
    if (n > env_step) begin
      wrapped = 5'(int'(env_step) - n);
      if (env_hold) begin
        if (env_alt) env_attack = env_attack ^ ENV_TOP;
        env_holding = 1'b1;
        env_step    = 5'd0;
      end else begin
        if (env_alt && wrapped[4]) env_attack = env_attack ^ ENV_TOP;
        env_step = wrapped;
      end
    end else begin
      env_step = env_step - 5'(n);
    end
  endfunction

  function automatic void gen_tick();
    int p;
    int n;
    for (int v = 0; v < NUM_VOICES; v++) begin
      tone_cnt[v]++;
      if (tone_cnt[v] >= voice_period(v)) begin
        tone_cnt[v] = 0;
        tone_hi[v]  = ~tone_hi[v];
      end
    end
    noise_cnt++;
    if (noise_cnt >= noise_span()) begin
      noise_cnt = 0;
      lfsr      = {lfsr[0] ^ lfsr[3], lfsr[16:1]};
      noise_hi  = lfsr[0];
    end
    if (!env_holding) begin
      p = env_period();
      env_cnt += 2;
      // a period of one moves the envelope two steps per tick
      if (env_cnt >= p) begin
        n = env_cnt / p;
        env_cnt -= n * p;
        env_advance(n);
      end
    end
  endfunction

  function automatic logic [4:0] voice_amp(input int v);
    logic [7:0] amp;
    amp = regs[REG_AMP_A + v];
    if ((!regs[REG_MIXER][v] && !tone_hi[v]) ||
        (!regs[REG_MIXER][v + NUM_VOICES] && !noise_hi)) return 5'd0;
    if (amp[4]) return env_step ^ env_attack;
    return (amp[3:0] == 4'd0) ? 5'd0 : {amp[3:0], 1'b1};
  endfunction

  function automatic mix_result_t predict(input logic [1:0] c, input logic [1:0] p,
                                          input logic [7:0] d, input logic [7:0] pa);
    mix_result_t r;
    logic [4:0]  va;
    logic [4:0]  vb;
    logic [4:0]  vc;
    r.rd_byte       = 8'hFF;
    r.port_b_strobe = 1'b0;
    case (c)
      CMD_WRITE: begin
        if (p == PORT_ADDR) begin
          sel = d[3:0];
        end else if (p == PORT_WRITE) begin
          reg_write(sel, d);
          r.port_b_strobe = (sel == REG_PORT_B);
        end
      end
      CMD_READ: begin
        if (p == PORT_READ) begin
          if (sel == REG_PORT_A && !regs[REG_MIXER][MIXER_PORT_A_OUT]) regs[REG_PORT_A] = pa;
          r.rd_byte = regs[sel];
        end
      end
      CMD_TICK: gen_tick();
      default: ;
    endcase
    va = voice_amp(0);
    vb = voice_amp(1);
    vc = voice_amp(2);
    r.left_level   = 6'(va) + 6'(vb);
    r.right_level  = 6'(va) + 6'(vc);
    r.port_b_value = regs[REG_PORT_B];
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch, expected %0h got %0h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      due_q.delete();
      errors = 0;
    end else begin
      if (req.valid && req.ready)
        due_q.push_back(predict(req.cmd, req.port, req.data, req.port_a_in));
      if (res.valid && res.ready) begin
        if (due_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result with no request outstanding", $realtime);
        end else begin
          due = due_q.pop_front();
          compare_field("rd_byte", due.rd_byte, res.rd_byte);
          compare_field("left_level", 8'(due.left_level), 8'(res.left_level));
          compare_field("right_level", 8'(due.right_level), 8'(res.right_level));
          compare_field("port_b_strobe", 8'(due.port_b_strobe), 8'(res.port_b_strobe));
          compare_field("port_b_value", due.port_b_value, res.port_b_value);
        end
      end
    end
    outstanding = due_q.size();
  end

endmodule

FILE: sim/tb_three_voice_sound_generator.sv
// Top of the sound generator testbench: clock, reset, request stimulus, result back-pressure.
module tb_three_voice_sound_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import tvsg_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] PORT_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1300;
  localparam int DRAIN_AT    = 900;
  localparam int STALL_AT    = 300;
  localparam int STALL_LEN   = 80;

  logic clk = 1'b0;
  logic rst;
  int   fails;
  int   pending;
  int   useful = 0;
  int   cyc = 0;
  int   stall_left = 0;
  bit   calm = 1'b0;

  tvsg_item_if   request_ch ();
  tvsg_result_if mix_ch ();

  three_voice_sound_generator dut (
    .clk    (clk),
    .rst    (rst),
    .item   (request_ch),
    .result (mix_ch)
  );

  tvsg_output_check out_check (
    .clk         (clk),
    .rst         (rst),
    .req         (request_ch),
    .res         (mix_ch),
    .errors      (fails),
    .outstanding (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      mix_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      mix_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (cyc == STALL_AT) begin
      mix_ch.ready <= 1'b0;
      stall_left   <= STALL_LEN;
    end else begin
      mix_ch.ready <= calm || ($urandom_range(0, 99) >= 22);
    end
  end

  task automatic issue(input logic [1:0] c, input logic [1:0] p, input logic [7:0] d,
                       input logic [7:0] pa);
    while (!calm && $urandom_range(0, 99) < 22) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
    end
    request_ch.valid     <= 1'b1;
    request_ch.cmd       <= c;
    request_ch.port      <= p;
    request_ch.data      <= d;
    request_ch.port_a_in <= pa;
    do @(posedge clk); while (!request_ch.ready);
    if (c == CMD_TICK || (c == CMD_WRITE && (p == PORT_ADDR || p == PORT_WRITE)) ||
        (c == CMD_READ && p == PORT_READ)) useful++;
  endtask

  task automatic set_reg(input logic [3:0] idx, input logic [7:0] v);
    issue(CMD_WRITE, PORT_ADDR, {4'($urandom), idx}, 8'($urandom));
    issue(CMD_WRITE, PORT_WRITE, v, 8'($urandom));
  endtask

  task automatic read_reg(input logic [3:0] idx, input logic [7:0] pa);
    issue(CMD_WRITE, PORT_ADDR, {4'($urandom), idx}, 8'($urandom));
    issue(CMD_READ, PORT_READ, 8'($urandom), pa);
  endtask

  task automatic wait_drained();
    request_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [3:0] idx;
    logic [7:0] val;
    bit         paused;
    paused = 1'b0;
    rst                  <= 1'b1;
    request_ch.valid     <= 1'b0;
    request_ch.cmd       <= CMD_TICK;
    request_ch.port      <= PORT_ADDR;
    request_ch.data      <= 8'h00;
    request_ch.port_a_in <= 8'hFF;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset state, forced mixer bits, port A, dead ports, unused command
    issue(CMD_TICK, PORT_ADDR, 8'h00, 8'hFF);
    set_reg(REG_MIXER, 8'hFF);
    set_reg(REG_AMP_A, 8'h0F);
    set_reg(4'(REG_AMP_A + 1), 8'h10);
    read_reg(REG_MIXER, 8'h00);
    read_reg(REG_PORT_A, 8'hA5);
    issue(CMD_READ, PORT_READ, 8'h00, 8'h5A);
    issue(CMD_READ, PORT_ADDR, 8'hFF, 8'h00);
    issue(CMD_READ, PORT_WRITE, 8'hFF, 8'h00);
    issue(CMD_READ, PORT_SPARE, 8'hFF, 8'h00);
    issue(CMD_WRITE, PORT_READ, 8'hFF, 8'hFF);
    issue(CMD_WRITE, PORT_SPARE, 8'h00, 8'h00);
    issue(CMD_UNUSED, PORT_WRITE, 8'hFF, 8'hFF);
    set_reg(REG_PORT_B, 8'hFF);
    set_reg(REG_ENV_SHAPE, 8'hFE);
    set_reg(4'(REG_NOISE - 1), 8'hFF);
    set_reg(REG_NOISE, 8'hFF);
    issue(CMD_TICK, PORT_SPARE, 8'hFF, 8'h00);

    while (useful < ITEM_TARGET) begin
      if (!paused && useful >= DRAIN_AT) begin
        wait_drained();
        paused = 1'b1;
      end
      calm <= (useful >= 500 && useful < 650);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          idx = 4'($urandom_range(0, NUM_REGS - 1));
          val = 8'($urandom);
          // keep periods short most of the time so the dividers actually turn over
          if ($urandom_range(0, 3) != 0) begin
            if (idx < REG_NOISE && !idx[0]) val = 8'($urandom_range(0, 12));
            else if (idx < REG_NOISE) val = {4'($urandom), 4'h0};
            else if (idx == REG_ENV_FINE) val = 8'($urandom_range(0, 4));
            else if (idx == REG_ENV_COARSE) val = 8'h00;
          end
          set_reg(idx, val);
        end
        3: read_reg(4'($urandom_range(0, NUM_REGS - 1)), 8'($urandom));
        9: issue(2'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
        default: repeat ($urandom_range(1, 24))
          issue(CMD_TICK, 2'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
